### rtl/lfcd_pkg.sv
// shared types and constants of the length framed command deframer
package lfcd_pkg;

  localparam int unsigned LFCD_MAX_FRAME_BYTES = 255;
  localparam int unsigned CFG_INDEX_W          = 2;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'h5A;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hA5;
  localparam logic [7:0] VALUE_WRITE_RST   = 8'h82;

  localparam logic [7:0] MIN_LENGTH         = 8'd2;
  localparam logic [7:0] VALUE_WRITE_LENGTH = 8'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_VALUE_WRITE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] value_write_command;
  } lfcd_cfg_t;

  typedef struct packed {
    logic [7:0]  command_code;
    logic [7:0]  declared_length;
    logic [15:0] word_address;
    logic [15:0] word_value;
    logic        is_value_write;
  } lfcd_result_t;

endpackage

### rtl/lfcd_cfg_regs.sv
// configuration registers of the deframer
module lfcd_cfg_regs
  import lfcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  output lfcd_cfg_t              cfg_o
);

  lfcd_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HEADER_FIRST:  cfg_d.header_first        = cfg_data_i;
        REG_HEADER_SECOND: cfg_d.header_second       = cfg_data_i;
        REG_VALUE_WRITE:   cfg_d.value_write_command = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first        <= HEADER_FIRST_RST;
      cfg_q.header_second       <= HEADER_SECOND_RST;
      cfg_q.value_write_command <= VALUE_WRITE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/lfcd_parser.sv
// per-byte frame parser state and result formation
module lfcd_parser
  import lfcd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = LFCD_MAX_FRAME_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   rx_byte_i,
  input  lfcd_cfg_t    cfg_i,
  output logic         res_valid_o,
  output lfcd_result_t res_o
);

  localparam logic [7:0] MaxLength = 8'(MAX_FRAME_BYTES - 3);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] value_q, value_d;
  logic        ok_q, ok_d;

  always_comb begin
    phase_d     = phase_q;
    seen_d      = seen_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    value_d     = value_q;
    ok_d        = ok_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      case (phase_q)
        PH_HEAD: begin
          if (seen_q == 8'd1) begin
            ok_d   = (rx_byte_i == cfg_i.header_second);
            seen_d = 8'd2;
          end else begin
            len_d  = rx_byte_i;
            seen_d = 8'd3;
            if (rx_byte_i < MIN_LENGTH || rx_byte_i > MaxLength) begin
              phase_d = PH_HUNT;
              seen_d  = '0;
              len_d   = '0;
              cmd_d   = '0;
              addr_d  = '0;
              value_d = '0;
              ok_d    = 1'b0;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (seen_q == 8'd3 && !ok_q) begin
            phase_d = PH_HUNT;
            seen_d  = '0;
            len_d   = '0;
            cmd_d   = '0;
            addr_d  = '0;
            value_d = '0;
            ok_d    = 1'b0;
          end else begin
            case (seen_q)
              8'd3:    cmd_d         = rx_byte_i;
              8'd4:    addr_d[15:8]  = rx_byte_i;
              8'd5:    addr_d[7:0]   = rx_byte_i;
              8'd6:    value_d[15:8] = rx_byte_i;
              8'd7:    value_d[7:0]  = rx_byte_i;
              default: cmd_d         = cmd_q;
            endcase
            seen_d = seen_q + 8'd1;
            if ({1'b0, seen_d} == {1'b0, len_q} + 9'd3) begin
              res_valid_o           = 1'b1;
              res_o.command_code    = cmd_d;
              res_o.declared_length = len_q;
              res_o.word_address    = addr_d;
              res_o.word_value      = value_d;
              res_o.is_value_write  = (cmd_d == cfg_i.value_write_command) &&
                                      (len_q == VALUE_WRITE_LENGTH);
              phase_d = PH_HUNT;
              seen_d  = '0;
              len_d   = '0;
              cmd_d   = '0;
              addr_d  = '0;
              value_d = '0;
              ok_d    = 1'b0;
            end
          end
        end
        default: begin
          phase_d = PH_HUNT;
          seen_d  = '0;
          len_d   = '0;
          cmd_d   = '0;
          addr_d  = '0;
          value_d = '0;
          ok_d    = 1'b0;
          if (rx_byte_i == cfg_i.header_first) begin
            phase_d = PH_HEAD;
            seen_d  = 8'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seen_q  <= '0;
      len_q   <= '0;
      cmd_q   <= '0;
      addr_q  <= '0;
      value_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      value_q <= value_d;
      ok_q    <= ok_d;
    end
  end

endmodule

### rtl/lfcd_out_buf.sv
// result register with skid stage
module lfcd_out_buf
  import lfcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lfcd_result_t push_data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lfcd_result_t out_data_o
);

  logic         out_v_q, out_v_d;
  logic         skid_v_q, skid_v_d;
  lfcd_result_t out_q, out_d;
  lfcd_result_t skid_q, skid_d;

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = push_i;
        skid_d   = push_data_i;
      end else begin
        out_v_d = push_i;
        out_d   = push_data_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

### rtl/length_framed_command_deframer.sv
// top level of the length framed command deframer
// a frame's result is registered into the output slot, or into the skid slot when that slot is busy
// throughput: one byte per cycle while the result side takes results
// the skid stage stalls input only when both result slots are full
// reset: asynchronous, active low; parser hunts, registers take their defaults
// no clearing pass after reset, input taken from the first cycle
module length_framed_command_deframer
  import lfcd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = LFCD_MAX_FRAME_BYTES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             command_code_o,
  output logic [7:0]             declared_length_o,
  output logic [15:0]            word_address_o,
  output logic [15:0]            word_value_o,
  output logic                   is_value_write_o
);

  lfcd_cfg_t    cfg;
  lfcd_result_t res;
  lfcd_result_t out_data;
  logic         res_valid;
  logic         accept;
  logic         full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  lfcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfcd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lfcd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign command_code_o    = out_data.command_code;
  assign declared_length_o = out_data.declared_length;
  assign word_address_o    = out_data.word_address;
  assign word_value_o      = out_data.word_value;
  assign is_value_write_o  = out_data.is_value_write;

endmodule

### rtl/lfcd_checker.sv
// port level checks of the deframer and their bind
module lfcd_checker
  import lfcd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [7:0]             command_code_o,
  input logic [7:0]             declared_length_o,
  input logic [15:0]            word_address_o,
  input logic [15:0]            word_value_o,
  input logic                   is_value_write_o
);

  // input stalls only while a result waits
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // a new result needs a byte transfer in the previous cycle
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without a byte transfer");

  // value write flag only on length five frames
  a_value_write_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_value_write_o) |-> (declared_length_o == VALUE_WRITE_LENGTH))
    else $error("value write flag on wrong length");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(command_code_o) &&
      $stable(declared_length_o) && $stable(word_address_o) &&
      $stable(word_value_o) && $stable(is_value_write_o)))
    else $error("stalled result changed");

endmodule

bind length_framed_command_deframer lfcd_checker u_lfcd_checker (.*);

### tb/length_framed_command_deframer_tb.sv
// testbench of the length framed command deframer: directed frames, random traffic, register sweeps
`timescale 1ns / 100ps

module length_framed_command_deframer_tb;
  import lfcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SCAN_HUNT = 2'd0,
    SCAN_HEAD = 2'd1,
    SCAN_BODY = 2'd2
  } scan_phase_e;

  typedef struct packed {
    logic [3:0]   count;
    logic [95:0]  seq;
    logic [7:0]   fill_count;
    logic [7:0]   fill_value;
    logic         has_want;
    lfcd_result_t want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [7:0]             cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [7:0]             rx_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [7:0]             command_code_o;
  logic [7:0]             declared_length_o;
  logic [15:0]            word_address_o;
  logic [15:0]            word_value_o;
  logic                   is_value_write_o;

  length_framed_command_deframer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .command_code_o    (command_code_o),
    .declared_length_o (declared_length_o),
    .word_address_o    (word_address_o),
    .word_value_o      (word_value_o),
    .is_value_write_o  (is_value_write_o)
  );

  // predictor state
  lfcd_cfg_t    regs_now;
  scan_phase_e  parse_state;
  logic [7:0]   frame_pos;
  logic [7:0]   frame_len;
  logic [7:0]   held_command;
  logic [15:0]  held_address;
  logic [15:0]  held_value;
  logic         header_match;
  lfcd_result_t pending_frames[$];

  bit sender_gaps_on = 1'b1;
  bit receiver_gaps_on = 1'b1;
  int hold_requests = 0;
  int mismatch_count = 0;
  int frames_checked = 0;
  int bytes_accepted = 0;
  int frame_bytes = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  stim_row_t directed_rows [16];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void clear_parser();
    parse_state  = SCAN_HUNT;
    frame_pos    = 8'd0;
    frame_len    = 8'd0;
    held_command = 8'd0;
    held_address = 16'd0;
    held_value   = 16'd0;
    header_match = 1'b0;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    lfcd_result_t done;
    case (parse_state)
      SCAN_HEAD: begin
        if (frame_pos == 8'd1) begin
          header_match = (b == regs_now.header_second);
          frame_pos = 8'd2;
        end else begin
          frame_len = b;
          frame_pos = 8'd3;
          if (b < MIN_LENGTH || int'(b) > LFCD_MAX_FRAME_BYTES - 3) clear_parser();
          else parse_state = SCAN_BODY;
        end
      end
      SCAN_BODY: begin
        if (frame_pos == 8'd3 && !header_match) begin
          clear_parser();
        end else begin
          case (frame_pos)
            8'd3: held_command = b;
            8'd4: held_address[15:8] = b;
            8'd5: held_address[7:0] = b;
            8'd6: held_value[15:8] = b;
            8'd7: held_value[7:0] = b;
            default: ;
          endcase
          frame_pos = frame_pos + 8'd1;
          if (int'(frame_pos) == int'(frame_len) + 3) begin
            done.command_code    = held_command;
            done.declared_length = frame_len;
            done.word_address    = held_address;
            done.word_value      = held_value;
            done.is_value_write  = (held_command == regs_now.value_write_command) &&
                                   (frame_len == VALUE_WRITE_LENGTH);
            pending_frames.push_back(done);
            clear_parser();
          end
        end
      end
      default: begin
        clear_parser();
        if (b == regs_now.header_first) begin
          parse_state = SCAN_HEAD;
          frame_pos = 8'd1;
        end
      end
    endcase
  endfunction

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    lfcd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result expected none actual cmd %h len %h",
                 $time, command_code_o, declared_length_o);
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        compare_field("command_code", 16'(want.command_code), 16'(command_code_o));
        compare_field("declared_length", 16'(want.declared_length), 16'(declared_length_o));
        compare_field("word_address", want.word_address, word_address_o);
        compare_field("word_value", want.word_value, word_value_o);
        compare_field("is_value_write", 16'(want.is_value_write), 16'(is_value_write_o));
      end
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin : result_receiver
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_gaps_on && ($urandom_range(99) < 24);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    while (sender_gaps_on && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    bytes_accepted++;
    parse_rx_byte(value);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_writes++;
    case (idx)
      REG_HEADER_FIRST:  regs_now.header_first = value;
      REG_HEADER_SECOND: regs_now.header_second = value;
      REG_VALUE_WRITE:   regs_now.value_write_command = value;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [7:0] first, input logic [7:0] second,
                               input logic [7:0] vw_cmd, input bit poke_unused);
    drain();
    if (poke_unused) write_register(REG_UNUSED, 8'($urandom_range(255)));
    write_register(REG_HEADER_FIRST, first);
    write_register(REG_HEADER_SECOND, second);
    write_register(REG_VALUE_WRITE, vw_cmd);
    cfg_valid_i <= 1'b0;
  endtask

  // header, length, then keep bytes of command and payload
  task automatic send_frame(input logic [7:0] second, input logic [7:0] len, input int keep);
    logic [7:0] b;
    send_byte(regs_now.header_first);
    send_byte(second);
    send_byte(len);
    frame_bytes += 3;
    for (int i = 0; i < keep; i++) begin
      if (i == 0) b = $urandom_range(1) ? regs_now.value_write_command : 8'($urandom_range(255));
      else if ($urandom_range(7) == 0) b = regs_now.header_first;
      else b = 8'($urandom_range(255));
      send_byte(b);
      frame_bytes++;
    end
  endtask

  function automatic logic [7:0] random_length();
    int pick;
    pick = $urandom_range(299);
    if (pick < 2) return 8'($urandom_range(200, 252));
    if (pick < 30) return 8'($urandom_range(9, 40));
    return 8'($urandom_range(2, 8));
  endfunction

  task automatic send_random_traffic(input int budget);
    int stop;
    int pick;
    logic [7:0] len;
    stop = frame_bytes + budget;
    while (frame_bytes < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = random_length();
        send_frame(regs_now.header_second, len, int'(len));
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (pick < 86) begin
        len = random_length();
        send_frame(regs_now.header_second ^ (8'd1 << $urandom_range(7)), len, 1);
      end else if (pick < 93) begin
        case ($urandom_range(4))
          0: len = 8'd0;
          1: len = 8'd1;
          2: len = 8'd253;
          3: len = 8'd254;
          default: len = 8'd255;
        endcase
        send_frame(regs_now.header_second, len, 0);
      end else begin
        len = random_length();
        send_frame(regs_now.header_second, len, $urandom_range(0, int'(len) - 1));
      end
    end
  endtask

  // result side holds off while short frames keep coming
  task automatic overfill_results();
    bit gaps_saved;
    gaps_saved = sender_gaps_on;
    sender_gaps_on = 1'b0;
    hold_requests++;
    repeat (15) send_frame(regs_now.header_second, 8'd2, 2);
    sender_gaps_on = gaps_saved;
  endtask

  initial begin : stimulus
    stim_row_t row;
    in_valid_i <= 1'b0;
    rx_byte_i <= 8'd0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_HEADER_FIRST;
    cfg_data_i <= 8'd0;
    rst_ni <= 1'b0;
    regs_now.header_first = HEADER_FIRST_RST;
    regs_now.header_second = HEADER_SECOND_RST;
    regs_now.value_write_command = VALUE_WRITE_RST;
    clear_parser();

    directed_rows = '{
      '{4'd8,  96'h5AA50582_1234ABCD_00000000, 8'd0, 8'h00, 1'b1,
        {8'h82, 8'h05, 16'h1234, 16'hABCD, 1'b1}},
      '{4'd5,  96'h5AA50211_FF000000_00000000, 8'd0, 8'h00, 1'b1,
        {8'h11, 8'h02, 16'hFF00, 16'h0000, 1'b0}},
      '{4'd6,  96'h5AA50322_01020000_00000000, 8'd0, 8'h00, 1'b1,
        {8'h22, 8'h03, 16'h0102, 16'h0000, 1'b0}},
      '{4'd7,  96'h5AA50482_FEDCBA00_00000000, 8'd0, 8'h00, 1'b1,
        {8'h82, 8'h04, 16'hFEDC, 16'hBA00, 1'b0}},
      '{4'd9,  96'h5AA50682_0000FFFF_77000000, 8'd0, 8'h00, 1'b1,
        {8'h82, 8'h06, 16'h0000, 16'hFFFF, 1'b0}},
      '{4'd8,  96'h5AA50500_00000000_00000000, 8'd0, 8'h00, 1'b1,
        {8'h00, 8'h05, 16'h0000, 16'h0000, 1'b0}},
      '{4'd8,  96'h5AA505FF_FFFFFFFF_00000000, 8'd0, 8'h00, 1'b1,
        {8'hFF, 8'h05, 16'hFFFF, 16'hFFFF, 1'b0}},
      // noise ahead of the header is skipped
      '{4'd8,  96'h00FFA55A_A5027F80_00000000, 8'd0, 8'h00, 1'b1,
        {8'h7F, 8'h02, 16'h8000, 16'h0000, 1'b0}},
      // wrong second header
      '{4'd8,  96'h5A000582_11223344_00000000, 8'd0, 8'h00, 1'b0, '0},
      // a header hidden in a dropped frame is not found again
      '{4'd7,  96'h5A005AA5_02334400_00000000, 8'd0, 8'h00, 1'b0, '0},
      // length zero, then a good frame
      '{4'd8,  96'h5AA5005A_A5020102_00000000, 8'd0, 8'h00, 1'b0, '0},
      '{4'd3,  96'h5AA50100_00000000_00000000, 8'd0, 8'h00, 1'b0, '0},
      '{4'd3,  96'h5AA5FD00_00000000_00000000, 8'd0, 8'h00, 1'b0, '0},
      '{4'd11, 96'h5AA5FF5A_A5058200_01000200, 8'd0, 8'h00, 1'b1,
        {8'h82, 8'h05, 16'h0001, 16'h0002, 1'b1}},
      // longest frame
      '{4'd8,  96'h5AA5FCFF_FFFFFFFF_00000000, 8'd247, 8'hFF, 1'b1,
        {8'hFF, 8'hFC, 16'hFFFF, 16'hFFFF, 1'b0}},
      '{4'd4,  96'h5A5AA502_00000000_00000000, 8'd0, 8'h00, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < 16; r++) begin
      row = directed_rows[r];
      for (int i = 0; i < int'(row.count); i++) send_byte(row.seq[95 - 8 * i -: 8]);
      repeat (int'(row.fill_count)) send_byte(row.fill_value);
      if (row.has_want && pending_frames.size() != 0)
        pending_frames[pending_frames.size() - 1] = row.want;
    end

    set_registers(HEADER_FIRST_RST, HEADER_SECOND_RST, VALUE_WRITE_RST, 1'b0);
    overfill_results();
    send_random_traffic(90);

    set_registers(8'h00, 8'h00, 8'h00, 1'b0);
    send_random_traffic(80);

    // long stretch with no idling on either side
    sender_gaps_on = 1'b0;
    receiver_gaps_on = 1'b0;
    set_registers(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_random_traffic(80);
    sender_gaps_on = 1'b1;
    receiver_gaps_on = 1'b1;

    row.fill_value = 8'($urandom_range(255));
    set_registers(row.fill_value, row.fill_value, 8'($urandom_range(255)), 1'b1);
    send_random_traffic(80);

    set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'b0);
    overfill_results();
    send_random_traffic(70);

    drain();
    $display("checked %0d frame results from %0d byte transfers, %0d register writes",
             frames_checked, bytes_accepted, cfg_writes);
    $display("covered short, long, truncated and broken frames under five header settings");
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               pending_frames.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
